[sv/rc4sc_pkg.sv]
// ----------------------------------------------------------------------------
// rc4sc_pkg
// Shared types and constants for the stream cipher: byte width, store
// depths, command codes, sequencer states and the permutation store request.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

  localparam int BYTE_W        = 8;
  localparam int PERM_DEPTH    = 1 << BYTE_W;
  localparam int MAX_KEY_BYTES = 256;
  localparam int KEY_CNT_W     = $clog2(MAX_KEY_BYTES + 1);
  localparam int KEY_IDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [KEY_CNT_W-1:0] key_cnt_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;

  typedef enum logic {
    CMD_KEY  = 1'b0,
    CMD_DATA = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_K0,
    ST_K1,
    ST_K2,
    ST_K3,
    ST_D0,
    ST_D1,
    ST_D2,
    ST_D3
  } state_t;

  typedef struct packed {
    logic  clr;
    logic  rd_en;
    byte_t rd_addr;
    logic  wr_en;
    byte_t wr_addr;
    byte_t wr_data;
  } perm_req_t;

endpackage

[sv/rc4sc_in_if.sv]
// ----------------------------------------------------------------------------
// rc4sc_in_if
// Input word channel: command, key or data byte, last-key flag.
// ----------------------------------------------------------------------------
interface rc4sc_in_if;
  import rc4sc_pkg::*;

  logic  valid;
  logic  ready;
  logic  command;
  byte_t value;
  logic  key_last;

  modport source (output valid, output command, output value, output key_last,
                  input ready);
  modport sink   (input valid, input command, input value, input key_last,
                  output ready);
endinterface

[sv/rc4sc_out_if.sv]
// ----------------------------------------------------------------------------
// rc4sc_out_if
// Result word channel: one ciphered byte per data word.
// ----------------------------------------------------------------------------
interface rc4sc_out_if;
  import rc4sc_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

[sv/rc4sc_perm_store.sv]
// ----------------------------------------------------------------------------
// rc4sc_perm_store
// Permutation memory: one write and one registered read per cycle. A flag
// per entry marks it written; an unwritten entry reads as its own address.
// ----------------------------------------------------------------------------
module rc4sc_perm_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rc4sc_pkg::perm_req_t  req,
  output rc4sc_pkg::byte_t      rd_data
);
  import rc4sc_pkg::*;

  byte_t                 mem [PERM_DEPTH];
  logic [PERM_DEPTH-1:0] written_r;
  byte_t                 rd_q_r;
  byte_t                 rd_addr_r;
  logic                  rd_written_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (req.clr) begin
      written_r <= '0;
    end else if (req.wr_en) begin
      written_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_written_r <= 1'b0;
    end else if (req.rd_en) begin
      rd_written_r <= written_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_q_r    <= mem[req.rd_addr];
      rd_addr_r <= req.rd_addr;
    end
  end

  assign rd_data = rd_written_r ? rd_q_r : rd_addr_r;

endmodule

[sv/rc4_stream_cipher.sv]
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// Byte stream cipher with key store, key schedule and keystream generator
// around one shared 8-bit adder and a permutation memory with one read and
// one write port.
//
//   channel     dir  fields                      handshake
//   in_stream   in   command, value, key_last    valid/ready
//   out_stream  out  out_byte                    valid/ready
//
// Key word: stored unless the store is full. Data word: accept, then four
// memory steps: read S[i], read S[j], swap and read S[t], final write and
// result. Last key word: clear, then one schedule step per entry; each step
// makes two dependent reads and two writes to the permutation memory.
// Reset takes effect at once: per-entry written flags give the identity.
// A data word holds in its last step while the result register is full.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
  input  logic clk,
  input  logic rst_n,
  rc4sc_in_if.sink    in_stream,
  rc4sc_out_if.source out_stream
);
  import rc4sc_pkg::*;

  state_t    state_r;
  state_t    state_nxt;
  perm_req_t perm_req;
  byte_t     perm_rd;

  byte_t    key_mem [MAX_KEY_BYTES];
  byte_t    key_q_r;
  key_cnt_t key_count_r;
  key_idx_t kidx_r;
  logic     key_rd_en;

  byte_t i_r;
  byte_t j_r;
  byte_t k_r;
  byte_t a_r;
  byte_t b_r;
  byte_t t_r;
  byte_t data_r;
  byte_t out_byte_r;
  logic  out_valid_r;

  byte_t add_a;
  byte_t add_b;
  byte_t add_c;
  byte_t add_sum;
  byte_t ks;

  logic in_acc;
  logic key_full;
  logic key_wr;
  logic kidx_last;
  logic k_last;
  logic d3_hold;

  rc4sc_perm_store u_perm (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (perm_req),
    .rd_data (perm_rd)
  );

  assign in_stream.ready   = (state_r == ST_IDLE);
  assign in_acc            = in_stream.valid && in_stream.ready;
  assign key_full          = (key_count_r == KEY_CNT_W'(MAX_KEY_BYTES));
  assign key_wr            = in_acc && (in_stream.command == CMD_KEY) && !key_full;
  assign kidx_last         = ((KEY_CNT_W'(kidx_r) + KEY_CNT_W'(1)) == key_count_r);
  assign k_last            = (k_r == BYTE_W'(PERM_DEPTH - 1));
  assign d3_hold           = out_valid_r && !out_stream.ready;
  assign add_sum           = add_a + add_b + add_c;
  assign ks                = (t_r == j_r) ? a_r : ((t_r == i_r) ? b_r : perm_rd);
  assign out_stream.valid    = out_valid_r;
  assign out_stream.out_byte = out_byte_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_stream.command == CMD_DATA) begin
            state_nxt = ST_D0;
          end else if (in_stream.key_last) begin
            state_nxt = ST_CLR;
          end
        end
      end
      ST_CLR:  state_nxt = ST_K0;
      ST_K0:   state_nxt = ST_K1;
      ST_K1:   state_nxt = ST_K2;
      ST_K2:   state_nxt = ST_K3;
      ST_K3:   state_nxt = k_last ? ST_IDLE : ST_K0;
      ST_D0:   state_nxt = ST_D1;
      ST_D1:   state_nxt = ST_D2;
      ST_D2:   state_nxt = ST_D3;
      ST_D3:   state_nxt = d3_hold ? ST_D3 : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    perm_req  = '0;
    key_rd_en = 1'b0;
    add_a     = j_r;
    add_b     = '0;
    add_c     = '0;
    case (state_r)
      ST_CLR: begin
        perm_req.clr = 1'b1;
      end
      ST_K0: begin
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = k_r;
        key_rd_en        = 1'b1;
      end
      ST_K1: begin
        add_b            = perm_rd;
        add_c            = key_q_r;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = add_sum;
      end
      ST_K2: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = k_r;
        perm_req.wr_data = perm_rd;
      end
      ST_K3: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = j_r;
        perm_req.wr_data = a_r;
      end
      ST_D0: begin
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = i_r;
      end
      ST_D1: begin
        add_b            = perm_rd;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = add_sum;
      end
      ST_D2: begin
        add_a            = a_r;
        add_b            = perm_rd;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = add_sum;
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = i_r;
        perm_req.wr_data = perm_rd;
      end
      ST_D3: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = j_r;
        perm_req.wr_data = a_r;
      end
      default: begin
        perm_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_mem[key_count_r[KEY_IDX_W-1:0]] <= in_stream.value;
    end
    if (key_rd_en) begin
      key_q_r <= key_mem[kidx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      kidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_D3) && !d3_hold) begin
        out_valid_r <= 1'b1;
      end else if (out_stream.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (key_wr) begin
            key_count_r <= key_count_r + KEY_CNT_W'(1);
          end
          if (in_acc && (in_stream.command == CMD_DATA)) begin
            i_r    <= i_r + BYTE_W'(1);
            data_r <= in_stream.value;
          end
        end
        ST_CLR: begin
          k_r    <= '0;
          j_r    <= '0;
          kidx_r <= '0;
        end
        ST_K1: begin
          a_r <= perm_rd;
          j_r <= add_sum;
        end
        ST_K3: begin
          k_r    <= k_r + BYTE_W'(1);
          kidx_r <= kidx_last ? '0 : kidx_r + KEY_IDX_W'(1);
          if (k_last) begin
            i_r         <= '0;
            j_r         <= '0;
            key_count_r <= '0;
          end
        end
        ST_D1: begin
          a_r <= perm_rd;
          j_r <= add_sum;
        end
        ST_D2: begin
          b_r <= perm_rd;
          t_r <= add_sum;
        end
        ST_D3: begin
          if (!d3_hold) begin
            out_byte_r <= data_r ^ ks;
          end
        end
        default: begin
          k_r <= k_r;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_D3) && !d3_hold |=> out_valid_r)
    else $error("data word finished without a result");

  a_key_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_stream.command == CMD_KEY) && in_stream.key_last |=> state_r == ST_CLR)
    else $error("last key word did not start the schedule");

  a_key_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= KEY_CNT_W'(MAX_KEY_BYTES))
    else $error("key count past store depth");

  a_schedule_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K0) |-> key_count_r != '0)
    else $error("schedule running with empty key");

  a_schedule_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K3) && k_last |=> (key_count_r == '0) && (i_r == '0) && (j_r == '0))
    else $error("schedule end left stale indices");
`endif

endmodule
